// ===== hdl/sbda_pkg.sv =====
// Shared types and constants of the sparse bitmask delta apply block.
package sbda_pkg;

  // Header layout, in bytes
  localparam int unsigned HDR_LEN    = 24;
  localparam int unsigned ENT_POS    = 16;
  localparam int unsigned STRIDE_POS = 20;
  localparam int unsigned MASK_ROUND = 7;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DELTA_LENGTH = 8'd0;
  localparam cfg_idx_t REG_OUTPUT_SIZE  = 8'd1;
  localparam cfg_idx_t REG_RANGE_BEGIN  = 8'd2;
  localparam cfg_idx_t REG_RANGE_END    = 8'd3;

  // Job status codes
  typedef logic [2:0] status_t;
  localparam status_t STAT_OK         = 3'd0;
  localparam status_t STAT_SHORT_HDR  = 3'd1;
  localparam status_t STAT_ZERO_STR   = 3'd2;
  localparam status_t STAT_SHORT_MASK = 3'd3;
  localparam status_t STAT_SHORT_PAY  = 3'd4;
  localparam status_t STAT_EMPTY_OUT  = 3'd5;
  localparam status_t STAT_TOO_MANY   = 3'd6;

  // Stream phase of the current job
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BITMASK,
    PH_PAYLOAD,
    PH_DONE,
    PH_ABORT
  } phase_e;

  // Sequencer state
  typedef enum logic [2:0] {
    SQ_IN,    // waiting for a stream beat
    SQ_MUL,   // set-bit count times stride
    SQ_CHK,   // length and output checks
    SQ_RD,    // bitmask byte read
    SQ_TEST,  // look for a set bit in the read byte
    SQ_BASE   // entity index times stride
  } seq_e;

  typedef struct packed {
    logic [7:0] delta_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        done_res;
    status_t     status;
  } out_item_t;

endpackage

// ===== hdl/sbda_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sbda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sparse_bitmask_delta_apply.sv =====
// Top level of the sparse bitmask delta apply block: parser, sequencer and checks.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_item_i): one beat per delta byte; last_byte
//    closes a job. A 24-byte header (entity count at offset 16, stride at offset 20),
//    the change bitmask, then one stride-byte record per set bitmask bit.
//  - out channel (out_valid_o/out_ready_i/out_item_o): one beat per byte write, and
//    one beat carrying done_res and status for the final byte of each job.
//  - cfg channel: register index and 32-bit data, always ready; write only when idle.
// Timing:
//  - each header, bitmask and payload byte is one beat; a result sits in the output
//    register the cycle after its beat is accepted.
//  - after the last bitmask byte: the shared multiplier, then the length checks.
//  - before each changed record: a scan of the stored bitmask, a RAM read and a bit
//    test per byte searched, then the multiplier for the record base.
//  - a beat is taken only in the input state while the output register is empty or being
//    drained, so a stalled receiver holds off the input after at most one buffered result.
// Reset clears the job state and registers to zero; the bitmask RAM is not cleared,
// only bytes written in the current job are ever read.
module sparse_bitmask_delta_apply
  import sbda_pkg::*;
#(
  parameter int unsigned ENT_CAP = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_idx_t    cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned MASK_DEPTH = (ENT_CAP + MASK_ROUND) / 8;
  localparam int unsigned MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
  localparam int unsigned BIT_W      = $clog2(MASK_DEPTH * 8 + 1);  // bit index / count
  localparam int unsigned MB_W       = $clog2(MASK_DEPTH + 1);      // bitmask byte count
  localparam int unsigned PROD_W     = BIT_W + 32;
  localparam int unsigned CMP_W      = BIT_W + 4;

  // configuration registers
  logic [31:0] delta_len_q, out_size_q, rng_begin_q, rng_end_q;

  // job state
  phase_e             phase_q, phase_d;
  seq_e               seq_q, seq_d;
  logic [4:0]         pos_q, pos_d;
  logic [31:0]        ent_total_q, ent_total_d;
  logic [31:0]        stride_q, stride_d;
  logic [MASK_AW-1:0] mi_q, mi_d;
  logic [BIT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  rem_q, rem_d;
  logic [BIT_W-1:0]   ent_q, ent_d;
  logic [31:0]        rec_off_q, rec_off_d;
  status_t            jstat_q, jstat_d;
  logic               last_q, last_d;
  logic [BIT_W-1:0]   scan_q, scan_d;
  logic [PROD_W-1:0]  prod_q, prod_d;

  // output register
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      push;
  logic      out_free;
  logic      in_fire;

  // bitmask RAM
  logic               mem_we, mem_re;
  logic [7:0]         mem_rdata;
  logic [BIT_W-4:0]   scan_byte;

  // helpers
  logic [BIT_W:0]     mb_sum;
  logic [MB_W-1:0]    mb_w;
  logic [MB_W+2:0]    bits_w;
  logic [PROD_W-1:0]  mul_p;
  logic [BIT_W-1:0]   mul_a;
  logic               rng_ok, fits;
  logic [7:0]         hit;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  function automatic logic [2:0] lsb8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int k = 7; k >= 0; k--) begin
      if (v[k]) begin
        p = 3'(k);
      end
    end
    return p;
  endfunction

  function automatic status_t end_status(input phase_e ph, input status_t js);
    status_t s;
    unique case (ph)
      PH_HEADER:  s = STAT_SHORT_HDR;
      PH_BITMASK: s = STAT_SHORT_MASK;
      PH_PAYLOAD: s = STAT_SHORT_PAY;
      PH_ABORT:   s = js;
      PH_DONE:    s = STAT_OK;
      default:    s = STAT_OK;
    endcase
    return s;
  endfunction

  // record base (low word of entity times stride) plus the byte offset
  function automatic logic [31:0] base_addr();
    return prod_q[31:0] + rec_off_q;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (seq_q == SQ_IN) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // bitmask byte count; only meaningful once the entity count passed its limit check
  assign mb_sum = {1'b0, ent_total_q[BIT_W-1:0]} + (BIT_W+1)'(MASK_ROUND);
  assign mb_w   = MB_W'(mb_sum >> 3);
  assign bits_w = {mb_w, 3'b000};

  // shared multiplier: set-bit count at the end of the bitmask, entity index per record
  assign mul_a = (seq_q == SQ_MUL) ? cnt_q : ent_q;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(stride_q);

  // write qualification for the current record, against live registers
  assign rng_ok = (32'(ent_q) >= rng_begin_q) && (32'(ent_q) < rng_end_q) &&
                  (32'(ent_q) < ent_total_q);
  assign fits   = ({1'b0, prod_q} + (PROD_W+1)'(stride_q)) <= (PROD_W+1)'(out_size_q);

  assign scan_byte = scan_q[BIT_W-1:3];
  assign hit       = mem_rdata & (8'hFF << scan_q[2:0]);

  sbda_ram #(
    .WIDTH (8),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mi_q),
    .wdata_i (in_item_i.delta_byte),
    .re_i    (mem_re),
    .raddr_i (MASK_AW'(scan_byte)),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    logic fin, we, clr;
    logic [31:0] addr;
    logic [PROD_W+1:0] total;

    phase_d     = phase_q;
    seq_d       = seq_q;
    pos_d       = pos_q;
    ent_total_d = ent_total_q;
    stride_d    = stride_q;
    mi_d        = mi_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    ent_d       = ent_q;
    rec_off_d   = rec_off_q;
    jstat_d     = jstat_q;
    last_d      = last_q;
    scan_d      = scan_q;
    prod_d      = prod_q;
    push        = 1'b0;
    res         = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    fin         = 1'b0;
    we          = 1'b0;
    clr         = 1'b0;
    addr        = base_addr();
    total       = (PROD_W+2)'(HDR_LEN) + (PROD_W+2)'(mb_w) + (PROD_W+2)'(prod_q);

    unique case (seq_q)
      SQ_IN: begin
        if (in_fire) begin
          unique case (phase_q)
            PH_HEADER: begin
              if (pos_q == '0 && delta_len_q < 32'(HDR_LEN)) begin
                phase_d = PH_ABORT;
                jstat_d = STAT_SHORT_HDR;
              end else begin
                if (pos_q >= 5'(ENT_POS) && pos_q < 5'(STRIDE_POS)) begin
                  ent_total_d[{pos_q[1:0], 3'b000} +: 8] = in_item_i.delta_byte;
                end else if (pos_q >= 5'(STRIDE_POS)) begin
                  stride_d[{pos_q[1:0], 3'b000} +: 8] = in_item_i.delta_byte;
                end
                if (pos_q == 5'(HDR_LEN - 1)) begin
                  if (stride_d == '0) begin
                    phase_d = PH_ABORT;
                    jstat_d = STAT_ZERO_STR;
                  end else if (ent_total_q > 32'(ENT_CAP)) begin
                    phase_d = PH_ABORT;
                    jstat_d = STAT_TOO_MANY;
                  end else if ({1'b0, delta_len_q} < 33'(HDR_LEN) + 33'(mb_w)) begin
                    phase_d = PH_ABORT;
                    jstat_d = STAT_SHORT_MASK;
                  end else if (mb_w == '0) begin
                    fin = 1'b1;
                  end else begin
                    phase_d = PH_BITMASK;
                  end
                end
                pos_d = pos_q + 5'd1;
              end
            end
            PH_BITMASK: begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + BIT_W'(popcnt8(in_item_i.delta_byte));
              if ((MB_W+1)'(mi_q) + (MB_W+1)'(1) == (MB_W+1)'(mb_w)) begin
                fin = 1'b1;
              end else begin
                mi_d = mi_q + MASK_AW'(1);
              end
            end
            PH_PAYLOAD: begin
              we    = rng_ok && fits;
              rem_d = rem_q - PROD_W'(1);
              if (rem_q == PROD_W'(1)) begin
                phase_d = PH_DONE;
              end else if ({1'b0, rec_off_q} + 33'd1 == {1'b0, stride_q}) begin
                // record complete: find the next changed entity
                rec_off_d = '0;
                scan_d    = ent_q + BIT_W'(1);
                seq_d     = SQ_RD;
              end else begin
                rec_off_d = rec_off_q + 32'd1;
              end
            end
            PH_DONE, PH_ABORT: begin
            end
            default: begin
            end
          endcase

          if (fin) begin
            last_d = in_item_i.last_byte;
            seq_d  = SQ_MUL;
          end else if (in_item_i.last_byte) begin
            push              = 1'b1;
            res.write_enable  = we;
            res.write_address = we ? addr : '0;
            res.write_data    = we ? in_item_i.delta_byte : '0;
            res.done_res      = 1'b1;
            res.status        = end_status(phase_d, jstat_d);
            clr               = 1'b1;
          end else if (we) begin
            push              = 1'b1;
            res.write_enable  = 1'b1;
            res.write_address = addr;
            res.write_data    = in_item_i.delta_byte;
          end
        end
      end
      SQ_MUL: begin
        prod_d = mul_p;
        seq_d  = SQ_CHK;
      end
      SQ_CHK: begin
        if (!last_q || out_free) begin
          if ((PROD_W+2)'(delta_len_q) < total) begin
            phase_d = PH_ABORT;
            jstat_d = STAT_SHORT_PAY;
          end else if (out_size_q == '0) begin
            phase_d = PH_ABORT;
            jstat_d = STAT_EMPTY_OUT;
          end else if (prod_q == '0) begin
            phase_d = PH_DONE;
          end else begin
            phase_d   = PH_PAYLOAD;
            rem_d     = prod_q;
            rec_off_d = '0;
            scan_d    = '0;
          end
          if (last_q) begin
            push         = 1'b1;
            res.done_res = 1'b1;
            res.status   = end_status(phase_d, jstat_d);
            clr          = 1'b1;
          end else begin
            seq_d = (phase_d == PH_PAYLOAD) ? SQ_RD : SQ_IN;
          end
        end
      end
      SQ_RD: begin
        if (CMP_W'(scan_q) >= CMP_W'(bits_w)) begin
          ent_d = BIT_W'(bits_w);
          seq_d = SQ_BASE;
        end else begin
          mem_re = 1'b1;
          seq_d  = SQ_TEST;
        end
      end
      SQ_TEST: begin
        if (hit != '0) begin
          ent_d = {scan_byte, lsb8(hit)};
          seq_d = SQ_BASE;
        end else begin
          scan_d = {scan_byte + (BIT_W-3)'(1), 3'b000};
          seq_d  = SQ_RD;
        end
      end
      SQ_BASE: begin
        prod_d = mul_p;
        seq_d  = SQ_IN;
      end
      default: begin
        seq_d = SQ_IN;
      end
    endcase

    if (clr) begin
      phase_d     = PH_HEADER;
      seq_d       = SQ_IN;
      pos_d       = '0;
      ent_total_d = '0;
      stride_d    = '0;
      mi_d        = '0;
      cnt_d       = '0;
      rem_d       = '0;
      ent_d       = '0;
      rec_off_d   = '0;
      jstat_d     = STAT_OK;
      last_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_len_q <= '0;
      out_size_q  <= '0;
      rng_begin_q <= '0;
      rng_end_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DELTA_LENGTH: delta_len_q <= cfg_data_i;
        REG_OUTPUT_SIZE:  out_size_q  <= cfg_data_i;
        REG_RANGE_BEGIN:  rng_begin_q <= cfg_data_i;
        REG_RANGE_END:    rng_end_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      seq_q       <= SQ_IN;
      pos_q       <= '0;
      ent_total_q <= '0;
      stride_q    <= '0;
      mi_q        <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      ent_q       <= '0;
      rec_off_q   <= '0;
      jstat_q     <= STAT_OK;
      last_q      <= 1'b0;
      scan_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      pos_q       <= pos_d;
      ent_total_q <= ent_total_d;
      stride_q    <= stride_d;
      mi_q        <= mi_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      ent_q       <= ent_d;
      rec_off_q   <= rec_off_d;
      jstat_q     <= jstat_d;
      last_q      <= last_d;
      scan_q      <= scan_d;
      prod_q      <= prod_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  // the record offset never reaches the stride while records are streaming
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rec_off_q < stride_q)
    else $error("record offset out of range");

  // payload phase always has bytes left while waiting for a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) && (seq_q == SQ_IN) |-> rem_q != '0)
    else $error("payload phase with nothing left");

  // byte writes only come from payload beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.write_enable |-> (phase_q == PH_PAYLOAD) && (seq_q == SQ_IN))
    else $error("write outside payload");

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !push)
    else $error("output register overrun");

  // bit test only follows a RAM read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SQ_TEST |-> $past(seq_q) == SQ_RD)
    else $error("bit test without read");

endmodule
